@@ hw/rtl/mi3_pkg.sv @@
// Shared widths, types and constants for the 3x3 matrix inverse core.
`timescale 1ns / 1ps

package mi3_pkg;

    // Entry format and element count.
    localparam int unsigned DW   = 32;
    localparam int unsigned FB   = 16;
    localparam int unsigned NE   = 9;
    localparam int unsigned NMUL = 18;

    // Intermediate widths.
    localparam int unsigned PW   = 2 * DW;         // product of two entries
    localparam int unsigned CW   = PW + 1;         // cofactor
    localparam int unsigned HW   = CW - DW;        // upper slice of a cofactor
    localparam int unsigned TMW  = DW + CW;        // entry times cofactor
    localparam int unsigned DETW = 3 * DW + 3;     // determinant
    localparam int unsigned SH   = 2 * FB;         // numerator scaling shift
    localparam int unsigned RW   = CW + SH;        // numerator magnitude / remainder
    localparam int unsigned SW   = DETW + SH;      // shifted divisor
    localparam int unsigned QW   = DW + 1;         // quotient bits incl. overflow bit
    localparam int unsigned TDW  = NE * DW;        // packed stream data width

    // Operand indexes of the two-entry products; pairs 2k and 2k+1 form cofactor k.
    localparam int unsigned MUL_A [NMUL] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int unsigned MUL_B [NMUL] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    // Saturation limits.
    localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

    // Cofactors and determinant leaving the front end.
    typedef struct packed {
        logic [NE-1:0][CW-1:0] cof;
        logic [DETW-1:0]       det;
    } cd_t;

    // Working set carried through the divider pipeline.
    typedef struct packed {
        logic [NE-1:0][RW-1:0] rem;
        logic [NE-1:0][QW-1:0] quo;
        logic [NE-1:0]         neg;
        logic [SW-1:0]         dsh;
        logic                  nz;
    } div_t;

endpackage

@@ hw/rtl/mi3_cof_det.sv @@
// Front end: two-entry products, cofactors and the determinant over five stages.
`timescale 1ns / 1ps

module mi3_cof_det (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [mi3_pkg::TDW-1:0] in_data,
    output logic                    out_valid,
    output mi3_pkg::cd_t            out_cd
);
    import mi3_pkg::*;

    logic signed [DW-1:0]  a [NE];
    logic signed [PW-1:0]  p1_reg [NMUL];
    logic signed [DW-1:0]  a1_reg [3];
    logic signed [CW-1:0]  cof2_reg [NE];
    logic signed [DW-1:0]  a2_reg [3];
    logic signed [TMW-1:0] lo3_reg [3];
    logic signed [TMW-1:0] hi3_reg [3];
    logic signed [CW-1:0]  cof3_reg [NE];
    logic signed [TMW-1:0] term4_reg [3];
    logic signed [CW-1:0]  cof4_reg [NE];
    logic signed [DETW-1:0] det5_reg;
    logic signed [CW-1:0]  cof5_reg [NE];
    logic signed [TMW-1:0] term_next [3];
    logic [4:0]            valid_reg;

    // Unpack the entries from the transfer.
    always_comb begin
        for (int i = 0; i < NE; i++) begin
            a[i] = in_data[i*DW +: DW];
        end
    end

    // Valid bits advance with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Recombine the split partial products of each determinant term.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            term_next[j] = (hi3_reg[j] <<< DW) + lo3_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 1: the eighteen products of two entries.
            for (int k = 0; k < NMUL; k++) begin
                p1_reg[k] <= a[MUL_A[k]] * a[MUL_B[k]];
            end
            for (int j = 0; j < 3; j++) begin
                a1_reg[j] <= a[j];
            end
            // Stage 2: cofactors of the adjugate.
            for (int k = 0; k < NE; k++) begin
                cof2_reg[k] <= CW'(p1_reg[2*k]) - CW'(p1_reg[2*k+1]);
            end
            a2_reg <= a1_reg;
            // Stage 3: first-row entry times its cofactor, cut in two partial products.
            for (int j = 0; j < 3; j++) begin
                lo3_reg[j] <= TMW'(a2_reg[j] * $signed({1'b0, cof2_reg[3*j][DW-1:0]}));
                hi3_reg[j] <= TMW'(a2_reg[j] * $signed(cof2_reg[3*j][CW-1:DW]));
            end
            cof3_reg <= cof2_reg;
            // Stage 4: the three terms of the first-row expansion.
            term4_reg <= term_next;
            cof4_reg  <= cof3_reg;
            // Stage 5: determinant.
            det5_reg <= DETW'(term4_reg[0]) + DETW'(term4_reg[1]) + DETW'(term4_reg[2]);
            cof5_reg <= cof4_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            out_cd.cof[k] = cof5_reg[k];
        end
        out_cd.det = det5_reg;
    end

    assign out_valid = valid_reg[4];

endmodule

@@ hw/rtl/mi3_div_step.sv @@
// One restoring division step for all nine quotients, with its pipeline register.
`timescale 1ns / 1ps

module mi3_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  mi3_pkg::div_t in_div,
    output logic          out_valid,
    output mi3_pkg::div_t out_div
);
    import mi3_pkg::*;

    div_t div_next;
    logic valid_reg;
    div_t div_reg;

    // Trial subtraction of the shifted divisor; the divisor then moves one bit down.
    always_comb begin
        logic ge;
        div_next = in_div;
        for (int k = 0; k < NE; k++) begin
            ge = SW'(in_div.rem[k]) >= in_div.dsh;
            if (ge) begin
                div_next.rem[k] = in_div.rem[k] - in_div.dsh[RW-1:0];
            end
            div_next.quo[k] = {in_div.quo[k][QW-2:0], ge};
        end
        div_next.dsh = in_div.dsh >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule

@@ hw/rtl/matrix_inverse_3x3_core.sv @@
// Top level of the 3x3 matrix inverse core: front end, divider pipeline and output stage.
`timescale 1ns / 1ps

// Inverts a 3x3 matrix of signed Q16.16 entries by the adjugate. One matrix can be
// transferred in every cycle while the pipeline is not held; each result passes through
// the pipeline: five stages of products, cofactors and determinant, one stage
// of magnitudes, one restoring divider stage per quotient bit (33, the top bit flags
// overflow) and the output register. Quotients round toward zero and saturate; a zero
// determinant clears the invertible flag on m_tuser and gives all-zero entries. The
// whole pipeline holds while a result waits on m_tready, so s_tready follows it.
module matrix_inverse_3x3_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, from the lowest bit up.
    input  logic [mi3_pkg::TDW-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, from the lowest bit up.
    output logic [mi3_pkg::TDW-1:0] m_tdata,
    // invertible.
    output logic                    m_tuser
);
    import mi3_pkg::*;

    logic             en;
    logic             cd_valid;
    cd_t              cd;
    logic             prep_valid_reg;
    div_t             prep_next;
    div_t             prep_reg;
    logic [QW:0]      dv;
    div_t             dd [QW+1];
    logic [TDW-1:0]   res_next;
    logic             out_valid_reg;
    logic [TDW-1:0]   out_data_reg;
    logic             out_inv_reg;

    // The pipeline moves whenever the output register is free or being emptied.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    mi3_cof_det u_cof_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (cd_valid),
        .out_cd    (cd)
    );

    // Magnitudes, quotient signs and the divisor aligned to the overflow bit.
    always_comb begin
        logic [CW-1:0]   cmag;
        logic [DETW-1:0] dmag;
        dmag = cd.det[DETW-1] ? DETW'(-cd.det) : cd.det;
        for (int k = 0; k < NE; k++) begin
            cmag = cd.cof[k][CW-1] ? CW'(-cd.cof[k]) : cd.cof[k];
            prep_next.rem[k] = {cmag, {SH{1'b0}}};
            prep_next.quo[k] = '0;
            prep_next.neg[k] = cd.cof[k][CW-1] ^ cd.det[DETW-1];
        end
        prep_next.dsh = {dmag, {SH{1'b0}}};
        prep_next.nz  = |cd.det;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign dv[0] = prep_valid_reg;
    assign dd[0] = prep_reg;

    // One quotient bit per stage, overflow bit first.
    for (genvar i = 0; i < QW; i++) begin : g_div
        mi3_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv[i]),
            .in_div    (dd[i]),
            .out_valid (dv[i+1]),
            .out_div   (dd[i+1])
        );
    end

    // Apply sign and saturation; a singular matrix gives zero entries.
    always_comb begin
        logic [QW-1:0] q;
        logic [DW-1:0] r;
        for (int k = 0; k < NE; k++) begin
            q = dd[QW].quo[k];
            if (!dd[QW].nz) begin
                r = '0;
            end else if (q[QW-1]) begin
                r = dd[QW].neg[k] ? SAT_NEG : SAT_POS;
            end else if (dd[QW].neg[k]) begin
                r = (q[DW-1:0] > SAT_NEG) ? SAT_NEG : DW'(-q[DW-1:0]);
            end else begin
                r = q[DW-1] ? SAT_POS : q[DW-1:0];
            end
            res_next[k*DW +: DW] = r;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= res_next;
            out_inv_reg  <= dd[QW].nz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_inv_reg;

endmodule

@@ sim/tb_matrix_inverse_3x3_core.sv @@
// Self-checking testbench for the 3x3 matrix inverse core.
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3_core;
    import mi3_pkg::*;

    localparam int unsigned  N_RANDOM   = 1000;
    localparam int unsigned  MAX_CYCLES = 400000;
    localparam int unsigned  DRAIN      = 60;
    localparam logic [DW-1:0] ONE       = 32'h0001_0000;

    // One expected inverse: nine packed entries and the invertible flag.
    typedef struct {
        logic [TDW-1:0] entries;
        logic           invertible;
    } inverse_t;

    // One matrix to send; known_result marks rows whose answer is typed in.
    typedef struct {
        logic [TDW-1:0] matrix;
        bit             known_result;
        inverse_t       answer;
    } matrix_row_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [TDW-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [TDW-1:0] m_tdata;
    logic           m_tuser;

    matrix_row_t    sent_rows[$];
    inverse_t       expected_inverses[$];
    matrix_row_t    directed_rows[$];
    int unsigned    mismatches = 0;
    int unsigned    cycle_count = 0;
    int unsigned    sender_idle_pct = 0;
    int unsigned    receiver_stall_pct = 0;

    matrix_inverse_3x3_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Packs nine entries, row by row, lowest bit first.
    function automatic logic [TDW-1:0] pack_matrix(input logic [DW-1:0] e [9]);
        logic [TDW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) begin
            d[i*DW +: DW] = e[i];
        end
        return d;
    endfunction

    // Exact inverse by the adjugate with truncating division and saturation.
    function automatic inverse_t compute_inverse(input logic [TDW-1:0] d);
        logic signed [DW-1:0]  entry;
        logic signed [255:0]   a [9];
        logic signed [255:0]   cof [9];
        logic signed [255:0]   det;
        logic signed [255:0]   quot;
        logic signed [255:0]   pos_lim;
        logic signed [255:0]   neg_lim;
        inverse_t              r;
        pos_lim = 256'sd2147483647;
        neg_lim = -256'sd2147483648;
        for (int i = 0; i < 9; i++) begin
            entry = d[i*DW +: DW];
            a[i] = entry;
        end
        det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
            - a[2]*a[4]*a[6] - a[0]*a[5]*a[7] - a[1]*a[3]*a[8];
        r.entries = '0;
        r.invertible = 1'b0;
        if (det == 0) begin
            return r;
        end
        cof[0] = a[4]*a[8] - a[5]*a[7];
        cof[1] = a[2]*a[7] - a[1]*a[8];
        cof[2] = a[1]*a[5] - a[2]*a[4];
        cof[3] = a[5]*a[6] - a[3]*a[8];
        cof[4] = a[0]*a[8] - a[2]*a[6];
        cof[5] = a[2]*a[3] - a[0]*a[5];
        cof[6] = a[3]*a[7] - a[4]*a[6];
        cof[7] = a[1]*a[6] - a[0]*a[7];
        cof[8] = a[0]*a[4] - a[1]*a[3];
        for (int k = 0; k < 9; k++) begin
            // Signed division in SystemVerilog truncates toward zero.
            quot = (cof[k] <<< (2 * FB)) / det;
            if (quot > pos_lim) begin
                r.entries[k*DW +: DW] = SAT_POS;
            end else if (quot < neg_lim) begin
                r.entries[k*DW +: DW] = SAT_NEG;
            end else begin
                r.entries[k*DW +: DW] = quot[DW-1:0];
            end
        end
        r.invertible = 1'b1;
        return r;
    endfunction

    // Builds a diagonal matrix with the given entries.
    function automatic logic [TDW-1:0] diag_matrix(input logic [DW-1:0] x, y, z);
        logic [DW-1:0] e [9];
        e = '{x, '0, '0, '0, y, '0, '0, '0, z};
        return pack_matrix(e);
    endfunction

    // Adds a directed row, typed in or left to the predictor.
    function automatic void add_row(input logic [TDW-1:0] m, input bit known,
                                    input logic [TDW-1:0] inv, input logic flag);
        matrix_row_t row;
        row.matrix = m;
        row.known_result = known;
        row.answer.entries = inv;
        row.answer.invertible = flag;
        directed_rows.push_back(row);
    endfunction

    // Random matrix: full-range noise, small well-conditioned values,
    // singular matrices with a repeated row or column, and tiny entries that saturate.
    function automatic logic [TDW-1:0] random_matrix();
        logic [DW-1:0] e [9];
        int unsigned   kind;
        int unsigned   src;
        int unsigned   dst;
        bit            by_row;
        kind = $urandom_range(99);
        for (int i = 0; i < 9; i++) begin
            if (kind < 30) begin
                e[i] = $urandom;
            end else if (kind < 85) begin
                e[i] = $urandom_range(32'h0008_0000) - 32'h0004_0000;
            end else begin
                e[i] = $urandom_range(30) - 15;
            end
        end
        if (kind >= 70 && kind < 85) begin
            src = $urandom_range(2);
            dst = (src + 1 + $urandom_range(1)) % 3;
            by_row = ($urandom_range(1) == 0);
            for (int j = 0; j < 3; j++) begin
                if (by_row) begin
                    e[dst*3 + j] = e[src*3 + j];
                end else begin
                    e[j*3 + dst] = e[j*3 + src];
                end
            end
        end
        return pack_matrix(e);
    endfunction

    // Sends one matrix, idling first at the current rate.
    task automatic send_matrix(input matrix_row_t row);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        sent_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.matrix;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_all_results();
        while (expected_inverses.size() != 0 || sent_rows.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Receiver back pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Transfer monitor: predicts on each input transfer and checks each result.
    always @(posedge aclk) begin
        matrix_row_t row;
        inverse_t    want;
        if (aresetn && s_tvalid && s_tready) begin
            row = sent_rows.pop_front();
            expected_inverses.push_back(row.known_result ? row.answer
                                                         : compute_inverse(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_inverses.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result data=%h flag=%b", $time, m_tdata, m_tuser);
            end else begin
                want = expected_inverses.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_tdata[k*DW +: DW] !== want.entries[k*DW +: DW]) begin
                        mismatches++;
                        $display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                                 want.entries[k*DW +: DW], m_tdata[k*DW +: DW]);
                    end
                end
                if (m_tuser !== want.invertible) begin
                    mismatches++;
                    $display("%0t: invertible expected %b actual %b", $time,
                             want.invertible, m_tuser);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("matrix_inverse_3x3_core regression: fail");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [DW-1:0] e [9];
        matrix_row_t   row;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed matrices: singular cases, identity, saturation and rounding.
        add_row('0, 1'b1, '0, 1'b0);
        add_row(diag_matrix(ONE, ONE, ONE), 1'b1, diag_matrix(ONE, ONE, ONE), 1'b1);
        add_row(diag_matrix(1, 1, 1), 1'b1, diag_matrix(SAT_POS, SAT_POS, SAT_POS), 1'b1);
        add_row(diag_matrix('1, '1, '1), 1'b1, diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG), 1'b1);
        add_row(diag_matrix(32'h0002_0000, 32'h0002_0000, 32'h0002_0000), 1'b1,
                diag_matrix(32'h0000_8000, 32'h0000_8000, 32'h0000_8000), 1'b1);
        e = '{default: 32'd7};
        add_row(pack_matrix(e), 1'b1, '0, 1'b0);
        e = '{default: SAT_POS};
        add_row(pack_matrix(e), 1'b1, '0, 1'b0);
        e = '{default: SAT_NEG};
        add_row(pack_matrix(e), 1'b1, '0, 1'b0);
        add_row(diag_matrix(SAT_POS, SAT_POS, SAT_POS), 1'b0, '0, 1'b0);
        add_row(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG), 1'b0, '0, 1'b0);
        add_row(diag_matrix(SAT_NEG, SAT_POS, ONE), 1'b0, '0, 1'b0);
        add_row(diag_matrix(32'h0003_0000, 32'hFFFD_0000, 32'h0007_0000), 1'b0, '0, 1'b0);
        e = '{'0, ONE, '0, ONE, '0, '0, '0, '0, ONE};
        add_row(pack_matrix(e), 1'b0, '0, 1'b0);
        e = '{SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, ONE, '0, SAT_NEG};
        add_row(pack_matrix(e), 1'b0, '0, 1'b0);
        e = '{32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0003_0000,
              32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0004_0000};
        add_row(pack_matrix(e), 1'b0, '0, 1'b0);
        e = '{32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFFE,
              32'h0000_000B, 32'h0000_000D, 32'h0000_0011, 32'hFFFF_FFED};
        add_row(pack_matrix(e), 1'b0, '0, 1'b0);
        foreach (directed_rows[i]) begin
            send_matrix(directed_rows[i]);
        end

        // Random matrices over four handshake phases.
        row.known_result = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            case (n / (N_RANDOM / 4))
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 54;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 54;
                end
                default: begin
                    sender_idle_pct = 18;
                    receiver_stall_pct = 18;
                end
            endcase
            // Let the pipeline drain completely once, after the first phase.
            if (n == N_RANDOM / 4) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_all_results();
            end
            row.matrix = random_matrix();
            send_matrix(row);
        end
        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (DRAIN) @(posedge aclk);

        if (mismatches == 0) begin
            $display("matrix_inverse_3x3_core regression: pass");
        end else begin
            $display("matrix_inverse_3x3_core regression: fail");
        end
        $finish;
    end

endmodule
